### rtl/cdq_pkg.sv
// Shared codes, widths and control types for the circular deque.
`default_nettype none

package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic reduce_step;
    logic exec;
    logic capture_read;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reduced;
    logic pop_read;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### rtl/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/cdq_datapath.sv
// Datapath: pointers, count, ring store, result and output registers.
`default_nettype none

module cdq_datapath #(
  parameter int MAX_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cdq_pkg::cmd_t                 cmd,
  output cdq_pkg::stat_t                     stat,
  input  wire logic                          cfg_valid,
  input  wire logic [cdq_pkg::CNT_W-1:0]     cfg_data,
  input  wire logic [cdq_pkg::REQ_W-1:0]     in_req,
  input  wire logic [cdq_pkg::DATA_W-1:0]    in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [cdq_pkg::DATA_W-1:0]    out_pop_value,
  output logic      [cdq_pkg::STAT_W-1:0]    out_status,
  output logic      [cdq_pkg::CNT_W-1:0]     out_count,
  output logic                               out_empty,
  output logic                               out_full
);

  localparam int PW = $clog2(MAX_DEPTH);
  localparam int CW = (PW > cdq_pkg::CNT_W) ? PW : cdq_pkg::CNT_W;
  localparam logic [cdq_pkg::CNT_W-1:0] CAP_LIM =
    (MAX_DEPTH > 31) ? 5'd31 : 5'(MAX_DEPTH);

  logic [cdq_pkg::CNT_W-1:0]  cap_cfg;
  logic [cdq_pkg::CNT_W-1:0]  cap;
  logic [CW-1:0]              cap_w;
  logic [PW-1:0]              front;
  logic [PW-1:0]              rear;
  logic [cdq_pkg::CNT_W-1:0]  count;
  logic [cdq_pkg::REQ_W-1:0]  req;
  logic [cdq_pkg::DATA_W-1:0] value;
  logic [PW-1:0]              wf;
  logic [PW-1:0]              wr;
  logic                       wf_hi;
  logic                       wr_hi;

  logic [cdq_pkg::DATA_W-1:0] res_pop;
  logic [cdq_pkg::STAT_W-1:0] res_status;
  logic [cdq_pkg::CNT_W-1:0]  res_count;
  logic                       res_empty;
  logic                       res_full;

  logic                       is_push;
  logic                       full_now;
  logic                       empty_now;
  logic [PW-1:0]              cap_top;
  logic [PW-1:0]              wf_up;
  logic [PW-1:0]              wf_down;
  logic [PW-1:0]              wr_up;
  logic [PW-1:0]              wr_down;
  logic [PW-1:0]              push_slot;
  logic [PW-1:0]              pop_slot;
  logic [cdq_pkg::CNT_W-1:0]  count_next;
  logic [PW-1:0]              front_next;
  logic [PW-1:0]              rear_next;
  logic [cdq_pkg::STAT_W-1:0] status_next;
  logic                       ram_we;
  logic                       ram_re;
  logic [cdq_pkg::DATA_W-1:0] ram_rdata;

  // Clamp the register: zero acts as one, above the store acts as the store size.
  always_comb begin
    if (cap_cfg == '0) begin
      cap = 5'd1;
    end else if (cap_cfg > CAP_LIM) begin
      cap = CAP_LIM;
    end else begin
      cap = cap_cfg;
    end
  end

  assign cap_w   = CW'(cap);
  assign cap_top = PW'(cap - 5'd1);
  assign wf_hi   = CW'(wf) >= cap_w;
  assign wr_hi   = CW'(wr) >= cap_w;

  assign wf_up   = (CW'(wf) + CW'(1) == cap_w) ? '0 : PW'(wf + PW'(1));
  assign wr_up   = (CW'(wr) + CW'(1) == cap_w) ? '0 : PW'(wr + PW'(1));
  assign wf_down = (wf == '0) ? cap_top : PW'(wf - PW'(1));
  assign wr_down = (wr == '0) ? cap_top : PW'(wr - PW'(1));

  assign is_push   = (req == cdq_pkg::REQ_PUSH_FRONT) || (req == cdq_pkg::REQ_PUSH_REAR);
  assign full_now  = count >= cap;
  assign empty_now = count == '0;

  always_comb begin
    if (empty_now) begin
      push_slot = (req == cdq_pkg::REQ_PUSH_FRONT) ? '0 : cap_top;
    end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
      push_slot = wf_up;
    end else begin
      push_slot = wr_down;
    end
  end

  assign pop_slot = (req == cdq_pkg::REQ_POP_FRONT) ? wf : wr;

  // Work out the request's effect; unchanged pointers keep their stored value.
  always_comb begin
    count_next  = count;
    front_next  = front;
    rear_next   = rear;
    status_next = cdq_pkg::ST_DONE;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (is_push) begin
      if (full_now) begin
        status_next = cdq_pkg::ST_FULL;
      end else begin
        ram_we     = cmd.exec;
        count_next = count + 5'd1;
        if (empty_now) begin
          front_next = push_slot;
          rear_next  = push_slot;
        end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
          front_next = push_slot;
        end else begin
          rear_next = push_slot;
        end
      end
    end else begin
      if (empty_now) begin
        status_next = cdq_pkg::ST_EMPTY;
      end else begin
        ram_re     = cmd.exec;
        count_next = count - 5'd1;
        if (count == 5'd1) begin
          front_next = '0;
          rear_next  = '0;
        end else if (req == cdq_pkg::REQ_POP_FRONT) begin
          front_next = wf_down;
        end else begin
          rear_next = wr_up;
        end
      end
    end
  end

  cdq_ram #(
    .WIDTH(cdq_pkg::DATA_W),
    .DEPTH(MAX_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(push_slot),
    .wdata(value),
    .re   (ram_re),
    .raddr(pop_slot),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg   <= cdq_pkg::CAP_RESET;
      front     <= '0;
      rear      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_cfg <= cfg_data;
      end
      if (cmd.exec) begin
        front <= front_next;
        rear  <= rear_next;
        count <= count_next;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req   <= in_req;
      value <= in_value;
      wf    <= front;
      wr    <= rear;
    end else if (cmd.reduce_step) begin
      // Bring both pointers below the capacity, one subtraction a cycle.
      if (wf_hi) begin
        wf <= PW'(CW'(wf) - cap_w);
      end
      if (wr_hi) begin
        wr <= PW'(CW'(wr) - cap_w);
      end
    end
    if (cmd.exec) begin
      res_pop    <= '0;
      res_status <= status_next;
      res_count  <= count_next;
      res_empty  <= count_next == '0;
      res_full   <= count_next >= cap;
    end else if (cmd.capture_read) begin
      res_pop <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_pop_value <= res_pop;
      out_status    <= res_status;
      out_count     <= res_count;
      out_empty     <= res_empty;
      out_full      <= res_full;
    end
  end

  assign stat.reduced  = !wf_hi && !wr_hi;
  assign stat.pop_read = !is_push && !empty_now;
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

### rtl/cdq_ctrl.sv
// Controller state machine that sequences one request at a time.
`default_nettype none

module cdq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cdq_pkg::stat_t stat,
  output cdq_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_NORM;
        end
      end
      S_NORM: begin
        if (stat.reduced) begin
          state_next = S_EXEC;
        end else begin
          cmd.reduce_step = 1'b1;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.pop_read ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.capture_read = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/circular_deque.sv
// Top level of the circular deque: controller, datapath and stream ports.
//
//  channel  direction  carries
//  s_axis   in         tuser: req_type[1:0]; tdata: push_value[31:0]
//  m_axis   out        tuser: status[1:0];
//                      tdata: pop_value[31:0], entry_count[36:32],
//                             is_empty[37], is_full[38], zero[39]
//  cfg      in         data: capacity_in_use[4:0], ready out of reset
//
// A push or rejected request passes from its transfer through NORM, EXEC and DONE
// to the output register, a successful pop also through READ (registered RAM read);
// s_axis_tready rises with m_axis_tvalid. After the capacity is lowered below a held
// pointer, NORM subtracts the capacity from each pointer until both are below it.
// A stalled result holds the output register; a following request then waits in DONE.
// Reset is synchronous: deque empty, capacity 16, store contents undefined.
`default_nettype none

module circular_deque #(
  parameter int MAX_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // push_value[31:0]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // pop_value, entry_count, is_empty, is_full, 0
  output logic      [1:0]  m_axis_tuser,   // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data        // capacity_in_use[4:0]
);

  cdq_pkg::cmd_t              cmd;
  cdq_pkg::stat_t             stat;
  logic [cdq_pkg::DATA_W-1:0] pop_value;
  logic [cdq_pkg::CNT_W-1:0]  entry_count;
  logic                       is_empty;
  logic                       is_full;

  assign cfg_ready = !rst;

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  cdq_datapath #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_req       (s_axis_tuser),
    .in_value     (s_axis_tdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_pop_value(pop_value),
    .out_status   (m_axis_tuser),
    .out_count    (entry_count),
    .out_empty    (is_empty),
    .out_full     (is_full)
  );

  assign m_axis_tdata = {1'b0, is_full, is_empty, entry_count, pop_value};

endmodule

`default_nettype wire

### rtl/circular_deque_checker.sv
// Port-level checker for the circular deque, bound to the top level.
`default_nettype none

module circular_deque_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // One request at a time: input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[37] == (m_axis_tdata[36:32] == 5'd0))
    else $error("is_empty disagrees with entry_count");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == cdq_pkg::ST_FULL |->
      m_axis_tdata[38] && m_axis_tdata[31:0] == 32'd0)
    else $error("full rejection without full flag or with data");

  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == cdq_pkg::ST_EMPTY |->
      m_axis_tdata[37] && m_axis_tdata[31:0] == 32'd0)
    else $error("empty rejection without empty flag or with data");

endmodule

bind circular_deque circular_deque_checker u_chk (.*);

`default_nettype wire

### dv/tb_circular_deque.sv
// Self-checking stream testbench for the circular deque: directed and random requests.
module tb_circular_deque;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 16;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int REPORT_MAX    = 10;
  localparam int NUM_PHASES    = 9;
  localparam int HOLD_PHASE    = 4;
  localparam int RANDOM_CAP    = -1;

  // Capacity, push share in percent and length of each random phase.
  localparam int PHASE_CAP[NUM_PHASES]  = '{1, 31, 3, 0, 16, 5, 17, 2, RANDOM_CAP};
  localparam int PHASE_PUSH[NUM_PHASES] = '{50, 70, 40, 50, 75, 35, 50, 50, 45};
  localparam int PHASE_LEN[NUM_PHASES]  = '{60, 90, 80, 50, 100, 80, 90, 60, 110};

  typedef struct packed {
    logic [cdq_pkg::REQ_W-1:0]  kind;
    logic [cdq_pkg::DATA_W-1:0] value;
  } deque_req_t;

  typedef struct packed {
    logic [cdq_pkg::DATA_W-1:0] pop_value;
    logic [cdq_pkg::STAT_W-1:0] status;
    logic [cdq_pkg::CNT_W-1:0]  entry_count;
    logic                       is_empty;
    logic                       is_full;
  } deque_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // push_value[31:0]
  logic [1:0]        s_axis_tuser = '0;   // req_type[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;        // pop_value, entry_count, is_empty, is_full, 0
  logic [1:0]        m_axis_tuser;        // status[1:0]
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [4:0]        cfg_data = '0;       // capacity_in_use[4:0]

  // Request stream and the results still owed by the block.
  deque_req_t        req_queue[$];
  deque_result_t     result_queue[$];
  int                taken_idx = 0;
  int                shown_idx = -1;

  // Shadow deque state.
  logic [cdq_pkg::DATA_W-1:0] deque_store[DEPTH];
  int                front_ptr = 0;
  int                rear_ptr = 0;
  int                held = 0;
  logic [cdq_pkg::CNT_W-1:0]  cap_setting = cdq_pkg::CAP_RESET;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                stall_req_cnt = 0;
  int                stall_done_cnt = 0;
  int                hold_left = 0;
  int                cycle_cnt = 0;
  int                mismatch_cnt = 0;
  int                push_cnt = 0;
  int                pop_cnt = 0;
  int                full_cnt = 0;
  int                empty_cnt = 0;

  circular_deque #(.MAX_DEPTH(DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               result_queue.size());
      $display("[circular_deque] ERROR");
      $finish;
    end
  end

  // Apply one request to the shadow deque and return what the block should report.
  function automatic deque_result_t deque_step(deque_req_t rq);
    deque_result_t r;
    int cap;
    int slot;
    cap = (cap_setting == 0) ? 1 : (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
    r.pop_value = '0;
    r.status = cdq_pkg::ST_DONE;
    if (rq.kind == cdq_pkg::REQ_PUSH_FRONT || rq.kind == cdq_pkg::REQ_PUSH_REAR) begin
      if (held >= cap) begin
        r.status = cdq_pkg::ST_FULL;
      end else begin
        if (held == 0) begin
          slot = (rq.kind == cdq_pkg::REQ_PUSH_FRONT) ? 0 : cap - 1;
          front_ptr = slot;
          rear_ptr = slot;
        end else if (rq.kind == cdq_pkg::REQ_PUSH_FRONT) begin
          slot = (front_ptr % cap + 1) % cap;
          front_ptr = slot;
        end else begin
          slot = (rear_ptr % cap + cap - 1) % cap;
          rear_ptr = slot;
        end
        deque_store[slot] = rq.value;
        held++;
      end
    end else if (held == 0) begin
      r.status = cdq_pkg::ST_EMPTY;
    end else begin
      if (rq.kind == cdq_pkg::REQ_POP_FRONT) begin
        slot = front_ptr % cap;
        front_ptr = (slot + cap - 1) % cap;
      end else begin
        slot = rear_ptr % cap;
        rear_ptr = (slot + 1) % cap;
      end
      r.pop_value = deque_store[slot];
      held--;
      if (held == 0) begin
        front_ptr = 0;
        rear_ptr = 0;
      end
    end
    r.entry_count = cdq_pkg::CNT_W'(held);
    r.is_empty = (held == 0);
    r.is_full = (held >= cap);
    return r;
  endfunction

  // Offer the next request; keep it steady until its transfer.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && shown_idx == taken_idx)) begin
      if (taken_idx < req_queue.size() && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req_queue[taken_idx].kind;
        s_axis_tdata <= req_queue[taken_idx].value;
        shown_idx <= taken_idx;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off.
  always @(negedge clk) begin
    if (stall_req_cnt != stall_done_cnt) begin
      stall_done_cnt <= stall_req_cnt;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    deque_result_t got;
    deque_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pop_value = m_axis_tdata[31:0];
        got.status = m_axis_tuser;
        got.entry_count = m_axis_tdata[36:32];
        got.is_empty = m_axis_tdata[37];
        got.is_full = m_axis_tdata[38];
        if (result_queue.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: unexpected result: pop %h status %0d count %0d empty %b full %b",
                     $realtime, got.pop_value, got.status, got.entry_count, got.is_empty,
                     got.is_full);
        end else begin
          want = result_queue.pop_front();
          if (want.status == cdq_pkg::ST_FULL) full_cnt++;
          if (want.status == cdq_pkg::ST_EMPTY) empty_cnt++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("%0t: exp/act pop %h/%h st %0d/%0d cnt %0d/%0d emp %b/%b full %b/%b",
                       $realtime, want.pop_value, got.pop_value, want.status, got.status,
                       want.entry_count, got.entry_count, want.is_empty, got.is_empty,
                       want.is_full, got.is_full);
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_setting = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        result_queue.push_back(deque_step(req_queue[taken_idx]));
        taken_idx <= taken_idx + 1;
      end
    end
  end

  task automatic add_item(input logic [cdq_pkg::REQ_W-1:0] kind,
                          input logic [cdq_pkg::DATA_W-1:0] value);
    deque_req_t rq;
    rq.kind = kind;
    rq.value = value;
    if (kind == cdq_pkg::REQ_PUSH_FRONT || kind == cdq_pkg::REQ_PUSH_REAR) push_cnt++;
    else pop_cnt++;
    req_queue.push_back(rq);
  endtask

  function automatic logic [cdq_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(input int push_pct);
    if ($urandom_range(99) < push_pct)
      add_item(($urandom_range(1) == 0) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_REAR,
               rand_word());
    else
      add_item(($urandom_range(1) == 0) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_REAR,
               rand_word());
  endtask

  // Hold the stream until every request has been taken and answered.
  task automatic wait_drained();
    while (taken_idx < req_queue.size() || result_queue.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cap;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pops, fill every slot through the wrap, full pushes, pops at both ends.
    send_idle_pct = 20;
    recv_idle_pct = 46;
    add_item(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
    add_item(cdq_pkg::REQ_POP_REAR, 32'hFFFF_FFFF);
    add_item(cdq_pkg::REQ_PUSH_REAR, 32'h8000_0000);
    add_item(cdq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    add_item(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
    add_item(cdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) add_item(cdq_pkg::REQ_PUSH_FRONT, $urandom);
    add_item(cdq_pkg::REQ_PUSH_FRONT, $urandom);
    add_item(cdq_pkg::REQ_PUSH_REAR, $urandom);
    add_item(cdq_pkg::REQ_POP_FRONT, $urandom);
    add_item(cdq_pkg::REQ_POP_REAR, $urandom);
    add_item(cdq_pkg::REQ_PUSH_REAR, 32'h5555_5555);
    wait_drained();

    // Random phases; capacity changes keep whatever is held, so some lower it under the count.
    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = (PHASE_CAP[p] == RANDOM_CAP) ? $urandom_range(16, 1) : PHASE_CAP[p];
      write_capacity(5'(cap));
      if (p < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 46;
      end else if (p < 6) begin
        send_idle_pct = 46;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == HOLD_PHASE) stall_req_cnt++;
      for (int i = 0; i < PHASE_LEN[p]; i++) add_random(PHASE_PUSH[p]);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d requests (%0d pushes, %0d pops) over %0d capacity settings",
             req_queue.size(), push_cnt, pop_cnt, NUM_PHASES);
    $display("Rejected %0d pushes when full and %0d pops when empty; %0d mismatches",
             full_cnt, empty_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && result_queue.size() == 0) begin
      $display("[circular_deque] OK");
    end else begin
      $display("[circular_deque] ERROR");
    end
    $finish;
  end

endmodule
